/* hw/rtl/bf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bf_pkg
// Shared types and constants for the brainfuck processor: request and result
// codes, command symbols, opcodes and the item structs of both channels.
// ----------------------------------------------------------------------------
package bf_pkg;

  // request codes
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_FINISH = 2'd1;
  localparam logic [1:0] REQ_STEP   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_OK     = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;
  localparam logic [1:0] KIND_HALTED = 2'd3;

  // program characters
  localparam logic [7:0] CHAR_RIGHT   = 8'h3E;
  localparam logic [7:0] CHAR_LEFT    = 8'h3C;
  localparam logic [7:0] CHAR_INC     = 8'h2B;
  localparam logic [7:0] CHAR_DEC     = 8'h2D;
  localparam logic [7:0] CHAR_OUT     = 8'h2E;
  localparam logic [7:0] CHAR_OPEN    = 8'h5B;
  localparam logic [7:0] CHAR_CLOSE   = 8'h5D;
  localparam logic [7:0] CHAR_COMMENT = 8'h25;
  localparam logic [7:0] CHAR_NL      = 8'h0A;

  // stored opcodes
  typedef enum logic [2:0] {
    OP_RIGHT = 3'd0,
    OP_LEFT  = 3'd1,
    OP_INC   = 3'd2,
    OP_DEC   = 3'd3,
    OP_OUT   = 3'd4,
    OP_OPEN  = 3'd5,
    OP_CLOSE = 3'd6,
    OP_NONE  = 3'd7
  } op_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] code_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
  } out_item_t;

  // map a program character to its opcode
  function automatic op_t decode_symbol(input logic [7:0] c);
    op_t op;
    unique case (c)
      CHAR_RIGHT: op = OP_RIGHT;
      CHAR_LEFT:  op = OP_LEFT;
      CHAR_INC:   op = OP_INC;
      CHAR_DEC:   op = OP_DEC;
      CHAR_OUT:   op = OP_OUT;
      CHAR_OPEN:  op = OP_OPEN;
      CHAR_CLOSE: op = OP_CLOSE;
      default:    op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/brainfuck_processor.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brainfuck_processor
// Loads program text into a program store with bracket targets resolved
// through a bracket stack, checks it on finish, then runs one instruction
// per step request against a byte-wide data memory.
// ----------------------------------------------------------------------------
//
//  channel | ports                          | moves
//  --------+--------------------------------+------------------------------
//  in      | in_valid, in_stall, in_item    | load / finish / step request
//  out     | out_valid, out_stall, out_item | output byte, ok, error, halted
//
//  A load writes the program store directly; a ']' load reads the bracket
//  stack, then writes the store twice. A step reads the program store and
//  data cell, then executes and writes back; a step with a result then loads
//  the output reg once it is free. A successful finish sweeps the data memory.
//  Reset needs no sweep: the data memory is only read after a finish.
//  Items are taken only in the idle state; a waiting result blocks only the
//  next result, not the next item.
//
module brainfuck_processor #(
  parameter int PROG_DEPTH = 65536,
  parameter int DATA_DEPTH = 32768
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire bf_pkg::in_item_t in_item,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output bf_pkg::out_item_t     out_item
);
  import bf_pkg::*;

  localparam int AW = $clog2(PROG_DEPTH);
  localparam int CW = $clog2(PROG_DEPTH + 1);
  localparam int DW = $clog2(DATA_DEPTH);

  typedef struct packed {
    op_t           op;
    logic [AW-1:0] target;
  } prog_ent_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LINK,
    S_CLOSE,
    S_CLEAR,
    S_EXEC,
    S_REPORT
  } state_t;

  typedef enum logic [1:0] {
    M_FRESH,
    M_LOADING,
    M_READY
  } mode_t;

  // memories
  prog_ent_t     prog_mem [PROG_DEPTH];
  logic [AW-1:0] stk_mem  [PROG_DEPTH];
  logic [7:0]    data_mem [DATA_DEPTH];

  prog_ent_t     prog_q;
  logic [AW-1:0] stk_q;
  logic [7:0]    data_q;

  // control registers
  state_t        state_r, state_nxt;
  mode_t         mode_r, mode_nxt;
  logic [CW-1:0] ic_r, ic_nxt;
  logic [CW-1:0] sp_r, sp_nxt;
  logic [CW-1:0] ip_r, ip_nxt;
  logic [DW-1:0] dp_r, dp_nxt;
  logic [DW-1:0] clr_r, clr_nxt;
  logic          cmt_r, cmt_nxt;
  logic          fail_r, fail_nxt;
  logic [1:0]    rep_kind_r, rep_kind_nxt;
  logic [7:0]    rep_byte_r, rep_byte_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_item_r, out_item_nxt;

  // memory port controls
  logic          pw_en, pr_en;
  logic [AW-1:0] pw_addr;
  prog_ent_t     pw_data;
  logic          sw_en, sr_en;
  logic [AW-1:0] sw_addr, sr_addr, sw_data;
  logic          dw_en, dr_en;
  logic [DW-1:0] dw_addr;
  logic [7:0]    dw_data;

  // load path: values after a possible start of a new program
  logic          new_prog;
  logic [CW-1:0] ic_eff, sp_eff, sp_dec;
  logic          cmt_eff, fail_eff;
  op_t           op_in;

  assign new_prog = (mode_r != M_LOADING);
  assign ic_eff   = new_prog ? '0 : ic_r;
  assign sp_eff   = new_prog ? '0 : sp_r;
  assign cmt_eff  = new_prog ? 1'b0 : cmt_r;
  assign fail_eff = new_prog ? 1'b0 : fail_r;
  assign sp_dec   = sp_eff - CW'(1);
  assign op_in    = decode_symbol(in_item.code_byte);

  assign sw_addr = sp_eff[AW-1:0];
  assign sw_data = ic_eff[AW-1:0];
  assign sr_addr = sp_dec[AW-1:0];

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // next-state and memory control
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    ic_nxt        = ic_r;
    sp_nxt        = sp_r;
    ip_nxt        = ip_r;
    dp_nxt        = dp_r;
    clr_nxt       = clr_r;
    cmt_nxt       = cmt_r;
    fail_nxt      = fail_r;
    rep_kind_nxt  = rep_kind_r;
    rep_byte_nxt  = rep_byte_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    pw_en         = 1'b0;
    pw_addr       = ic_r[AW-1:0];
    pw_data       = '{op: OP_NONE, target: '0};
    pr_en         = 1'b0;
    sw_en         = 1'b0;
    sr_en         = 1'b0;
    dw_en         = 1'b0;
    dw_addr       = dp_r;
    dw_data       = '0;
    dr_en         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_item.req_type)
            REQ_LOAD: begin
              mode_nxt = M_LOADING;
              ic_nxt   = ic_eff;
              sp_nxt   = sp_eff;
              cmt_nxt  = cmt_eff;
              fail_nxt = fail_eff;
              if (!fail_eff) begin
                priority if (cmt_eff) begin
                  if (in_item.code_byte == CHAR_NL) cmt_nxt = 1'b0;
                end else if (in_item.code_byte == CHAR_COMMENT) begin
                  cmt_nxt = 1'b1;
                end else if (op_in != OP_NONE) begin
                  priority if (op_in == OP_CLOSE && sp_eff == '0) begin
                    fail_nxt = 1'b1;
                  end else if (ic_eff == CW'(PROG_DEPTH)) begin
                    fail_nxt = 1'b1;
                  end else if (op_in == OP_CLOSE) begin
                    // fetch the partner index, then link in S_LINK and S_CLOSE
                    sr_en     = 1'b1;
                    state_nxt = S_LINK;
                  end else begin
                    pw_en   = 1'b1;
                    pw_addr = ic_eff[AW-1:0];
                    pw_data = '{op: op_in, target: '0};
                    ic_nxt  = ic_eff + CW'(1);
                    if (op_in == OP_OPEN) begin
                      sw_en  = 1'b1;
                      sp_nxt = sp_eff + CW'(1);
                    end
                  end
                end
              end
            end
            REQ_FINISH: begin
              ic_nxt       = ic_eff;
              sp_nxt       = sp_eff;
              cmt_nxt      = cmt_eff;
              fail_nxt     = fail_eff;
              rep_byte_nxt = '0;
              if (!fail_eff && sp_eff == '0) begin
                mode_nxt     = M_READY;
                dp_nxt       = '0;
                ip_nxt       = '0;
                clr_nxt      = '0;
                rep_kind_nxt = KIND_OK;
                state_nxt    = S_CLEAR;
              end else begin
                mode_nxt     = M_FRESH;
                rep_kind_nxt = KIND_ERROR;
                state_nxt    = S_REPORT;
              end
            end
            REQ_STEP: begin
              if (mode_r != M_READY || ip_r >= ic_r) begin
                rep_kind_nxt = KIND_HALTED;
                rep_byte_nxt = '0;
                state_nxt    = S_REPORT;
              end else begin
                pr_en     = 1'b1;
                dr_en     = 1'b1;
                state_nxt = S_EXEC;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // open bracket points to this close bracket
      S_LINK: begin
        pw_en     = 1'b1;
        pw_addr   = stk_q;
        pw_data   = '{op: OP_OPEN, target: ic_r[AW-1:0]};
        state_nxt = S_CLOSE;
      end

      // close bracket points back to its open bracket
      S_CLOSE: begin
        pw_en     = 1'b1;
        pw_addr   = ic_r[AW-1:0];
        pw_data   = '{op: OP_CLOSE, target: stk_q};
        ic_nxt    = ic_r + CW'(1);
        sp_nxt    = sp_r - CW'(1);
        state_nxt = S_IDLE;
      end

      // zero sweep of the data memory
      S_CLEAR: begin
        dw_en   = 1'b1;
        dw_addr = clr_r;
        clr_nxt = clr_r + DW'(1);
        if (clr_r == DW'(DATA_DEPTH - 1)) state_nxt = S_REPORT;
      end

      // execute with the fetched instruction and cell
      S_EXEC: begin
        ip_nxt    = ip_r + CW'(1);
        state_nxt = S_IDLE;
        unique case (prog_q.op)
          OP_RIGHT: dp_nxt = (dp_r == DW'(DATA_DEPTH - 1)) ? '0 : dp_r + DW'(1);
          OP_LEFT:  dp_nxt = (dp_r == '0) ? DW'(DATA_DEPTH - 1) : dp_r - DW'(1);
          OP_INC: begin
            dw_en   = 1'b1;
            dw_data = data_q + 8'd1;
          end
          OP_DEC: begin
            dw_en   = 1'b1;
            dw_data = data_q - 8'd1;
          end
          OP_OUT: begin
            rep_kind_nxt = KIND_BYTE;
            rep_byte_nxt = data_q;
            state_nxt    = S_REPORT;
          end
          OP_OPEN: begin
            if (data_q == 8'd0) ip_nxt = CW'(prog_q.target) + CW'(1);
          end
          OP_CLOSE: begin
            if (data_q != 8'd0) ip_nxt = CW'(prog_q.target) + CW'(1);
          end
          default: begin
          end
        endcase
      end

      // hand the result to the output register once it is free
      S_REPORT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{kind: rep_kind_r, out_byte: rep_byte_r};
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= M_FRESH;
      ic_r        <= '0;
      sp_r        <= '0;
      ip_r        <= '0;
      dp_r        <= '0;
      clr_r       <= '0;
      cmt_r       <= 1'b0;
      fail_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      ic_r        <= ic_nxt;
      sp_r        <= sp_nxt;
      ip_r        <= ip_nxt;
      dp_r        <= dp_nxt;
      clr_r       <= clr_nxt;
      cmt_r       <= cmt_nxt;
      fail_r      <= fail_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rep_kind_r <= rep_kind_nxt;
    rep_byte_r <= rep_byte_nxt;
    out_item_r <= out_item_nxt;
  end

  // program store
  always_ff @(posedge clk) begin
    if (pw_en) prog_mem[pw_addr] <= pw_data;
    if (pr_en) prog_q <= prog_mem[ip_r[AW-1:0]];
  end

  // bracket stack
  always_ff @(posedge clk) begin
    if (sw_en) stk_mem[sw_addr] <= sw_data;
    if (sr_en) stk_q <= stk_mem[sr_addr];
  end

  // data memory
  always_ff @(posedge clk) begin
    if (dw_en) data_mem[dw_addr] <= dw_data;
    if (dr_en) data_q <= data_mem[dp_r];
  end

  // open brackets never outnumber stored instructions
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= ic_r) else $error("bracket stack deeper than program");

  // instruction count stays within the program store
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ic_r <= CW'(PROG_DEPTH)) else $error("instruction count past store");

  // execution only on a runnable program inside its bounds
  a_exec_ok: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |-> mode_r == M_READY && ip_r < ic_r)
    else $error("execute outside a runnable program");

  // a bracket link is always followed by the close bracket write
  a_link_close: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LINK |=> state_r == S_CLOSE)
    else $error("bracket link not completed");

  // the end of the sweep reports compile ok
  a_clear_ok: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR && clr_r == DW'(DATA_DEPTH - 1)
    |=> state_r == S_REPORT && rep_kind_r == KIND_OK)
    else $error("sweep did not end in compile ok");

endmodule
`default_nettype wire
